// ===== rtl/olarf_pkg.sv =====
// Package for the ordered list block: command and status codes, controller
// states and the per-cell control group. No dependencies.
package olarf_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   // entries examined per scan cycle during a find
   localparam int GROUP = 8;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic load;       // store the appended value
      logic take_next;  // copy the right-hand neighbour (gap closing)
      logic live;       // cell lies below the count
   } cell_ctl_type;

endpackage

// ===== rtl/olarf_cell.sv =====
// One storage cell of the list chain: holds an entry, shifts from its
// neighbour on removal and registers its own match against the search key.
// Depends on olarf_pkg.
module olarf_cell #(
   parameter int DATA_WIDTH = olarf_pkg::DATA_WIDTH
) (
   input  logic                    clock,
   input  olarf_pkg::cell_ctl_type ctl,
   input  logic [DATA_WIDTH-1:0]   value,
   input  logic [DATA_WIDTH-1:0]   next_data,
   input  logic [DATA_WIDTH-1:0]   key,
   output logic [DATA_WIDTH-1:0]   data,
   output logic                    hit
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic                  hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= value;
      end else if (ctl.take_next) begin
         data_ff <= next_data;
      end
      hit_ff <= ctl.live && (data_ff == key);
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

// ===== rtl/ordered_list_append_remove_find.sv =====
// Ordered list: append, remove-at-position and find over a chain of cells.
// Append, remove and the unused command: result strobe the cycle after
// acceptance, busy stays low, a new command every cycle.
// Find passes a compare state, then a scan of eight match bits per cycle,
// busy high meanwhile; an empty list ends at the first scan step. Results cannot be stalled.
// Synchronous reset empties the list; entry contents are not cleared.
module ordered_list_append_remove_find #(
   parameter int CAPACITY   = olarf_pkg::CAPACITY,
   parameter int DATA_WIDTH = olarf_pkg::DATA_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_position,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_found_position,
   output logic [6:0]         rsp_entry_count
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int GRP = olarf_pkg::GROUP;
   localparam int NG  = (CAPACITY + GRP - 1) / GRP;
   localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
   localparam int GBW = $clog2(GRP);
   localparam int W0  = (CW > GW + GBW + 1) ? CW : GW + GBW + 1;
   localparam int W   = (W0 > 7) ? W0 : 7;

   olarf_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [GW-1:0]         group_ff, group_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   olarf_pkg::status_type status_ff, status_in;
   logic [5:0]            found_ff, found_in;

   logic                      accept;
   logic                      append_go;
   logic                      remove_go;
   logic [DATA_WIDTH+31:0]    value_ext;
   logic [DATA_WIDTH-1:0]     value_trim;
   logic [W-1:0]              pos_ext;
   logic [W-1:0]              count_ext;
   logic [CAPACITY-1:0]       hits;
   logic [NG*GRP-1:0]         hit_pad;
   logic [GRP-1:0]            group_bits;
   logic [GBW-1:0]            enc;
   logic [W-1:0]              found_ext;
   logic [W-1:0]              group_end;

   logic [DATA_WIDTH-1:0]     data [CAPACITY];
   olarf_pkg::cell_ctl_type   ctl  [CAPACITY];

   assign accept     = start && !busy;
   assign busy       = (state_ff != olarf_pkg::S_IDLE);
   assign value_ext  = {{DATA_WIDTH{1'b0}}, req_value};
   assign value_trim = value_ext[DATA_WIDTH-1:0];
   assign pos_ext    = W'(req_position);
   assign count_ext  = W'(count_ff);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [W-1:0] IDX = W'(i);
      logic [DATA_WIDTH-1:0] next_data;

      if (i == CAPACITY - 1) begin : g_last
         assign next_data = data[i];
      end else begin : g_mid
         assign next_data = data[i+1];
      end

      assign ctl[i].load      = append_go && (IDX == count_ext);
      assign ctl[i].take_next = remove_go && (IDX >= pos_ext);
      assign ctl[i].live      = (IDX < count_ext);

      olarf_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl[i]),
         .value    (value_trim),
         .next_data(next_data),
         .key      (key_ff),
         .data     (data[i]),
         .hit      (hits[i])
      );
   end

   assign hit_pad    = (NG*GRP)'(hits);
   assign group_bits = hit_pad[{group_ff, GBW'(0)} +: GRP];
   assign group_end  = W'({group_ff, GBW'(0)}) + W'(GRP);

   // first set bit of the current group wins
   always_comb begin
      enc = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
         if (group_bits[k]) enc = GBW'(k);
      end
   end

   assign found_ext = W'({group_ff, enc});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      group_in     = group_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      found_in     = found_ff;
      append_go    = 1'b0;
      remove_go    = 1'b0;
      unique case (state_ff)
         olarf_pkg::S_IDLE: begin
            if (accept) begin
               found_in = '0;
               unique case (olarf_pkg::command_type'(req_command))
                  olarf_pkg::CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = olarf_pkg::ST_FULL;
                     end else begin
                        append_go = 1'b1;
                        count_in  = count_ff + CW'(1);
                        status_in = olarf_pkg::ST_OK;
                     end
                  end
                  olarf_pkg::CMD_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (pos_ext >= count_ext) begin
                        status_in = olarf_pkg::ST_BAD_POS;
                     end else begin
                        remove_go = 1'b1;
                        count_in  = count_ff - CW'(1);
                        status_in = olarf_pkg::ST_OK;
                     end
                  end
                  olarf_pkg::CMD_FIND: begin
                     key_in   = value_trim;
                     state_in = olarf_pkg::S_COMPARE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = olarf_pkg::ST_OK;
                  end
               endcase
            end
         end
         olarf_pkg::S_COMPARE: begin
            // cells register their match bits this cycle
            group_in = '0;
            state_in = olarf_pkg::S_SCAN;
         end
         olarf_pkg::S_SCAN: begin
            if (|group_bits) begin
               rsp_valid_in = 1'b1;
               status_in    = olarf_pkg::ST_OK;
               found_in     = found_ext[5:0];
               state_in     = olarf_pkg::S_IDLE;
            end else if (group_end >= count_ext) begin
               rsp_valid_in = 1'b1;
               status_in    = olarf_pkg::ST_NOT_FOUND;
               found_in     = '0;
               state_in     = olarf_pkg::S_IDLE;
            end else begin
               group_in = group_ff + GW'(1);
            end
         end
         default: begin
            state_in = olarf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olarf_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff  <= group_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_entry_count    = count_ext[6:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != olarf_pkg::S_IDLE) |=> $stable(count_ff))
      else $error("entry count changed during a find");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(accept) || $past(state_ff == olarf_pkg::S_SCAN)))
      else $error("result strobe without a transaction");

   a_found_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == olarf_pkg::S_SCAN && (|group_bits)) |-> (found_ext < count_ext))
      else $error("match reported beyond the count");

endmodule
